// ===== hw/rtl/pcfk_pkg.sv =====
// Shared types, constants and saturation helpers for the planar chain kinematics block.
`timescale 1ns / 1ps

package pcfk_pkg;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAR_COUNT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIXED_MASK  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIXED_LOW   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIXED_HIGH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_DEG   = 3'd4;

   // Angle to 32-bit phase scale factors (one turn = 2^32), Q16
   localparam logic [32:0] K_RAD = 33'd5468522205;
   localparam logic [32:0] K_DEG = 33'd6108397932;

   // CORDIC gain compensation, Q16
   localparam logic [32:0] GAIN_Q16 = 33'd39797;

   // Rounding constant for the Q16 fraction of the rotated vector
   localparam int RND_HALF = 32768;

   // Rotation datapath widths
   localparam int XY_W = 36;
   localparam int Z_W  = 34;

   // Arctangent table in turns scaled by 2^32
   localparam int ATAN_DEPTH = 24;
   localparam int ATAN_IDX_W = 5;
   localparam logic [31:0] ATAN_TURN [ATAN_DEPTH] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   // Rotator sequencer states
   typedef enum logic [2:0] {
      ROT_IDLE,
      ROT_PHASE,
      ROT_GAIN,
      ROT_ITER,
      ROT_ROUND,
      ROT_HOLD
   } rot_state_type;

   // One rotation job
   typedef struct packed {
      logic [15:0]        len;
      logic signed [15:0] angle;
      logic               degrees;
   } rot_op_type;

   // One rotated segment
   typedef struct packed {
      logic signed [16:0] dx;
      logic signed [16:0] dy;
   } rot_result_type;

   // Handshake between chain control and rotator
   typedef struct packed {
      logic idle;
      logic res_valid;
   } rot_status_type;

   // Saturate to the segment range of +-65535
   function automatic logic signed [16:0] sat_seg(input logic signed [20:0] v);
      logic signed [16:0] r;
      if (v > 21'sd65535) begin
         r = 17'sd65535;
      end else if (v < -21'sd65535) begin
         r = -17'sd65535;
      end else begin
         r = v[16:0];
      end
      return r;
   endfunction

   // Saturate to the 20-bit signed end point range
   function automatic logic signed [19:0] sat_run(input logic signed [20:0] v);
      logic signed [19:0] r;
      if (v > 21'sd524287) begin
         r = 20'sd524287;
      end else if (v < -21'sd524288) begin
         r = -20'sd524288;
      end else begin
         r = v[19:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/planar_chain_forward_kinematics.sv =====
// Top level: configuration registers, chain bookkeeping and result word register.
`timescale 1ns / 1ps

// Each accepted word is one bar; the block answers with one result word per bar,
// carrying the segment vector, the running end point, the bar index and tlast on
// the final bar. With bar_count zero a word is taken and dropped. A bar goes from
// acceptance to a valid result by two passes through the shared multiplier for
// phase and gain scaling, one CORDIC step per cycle in a single shift-add unit,
// a rounding step and a load of the result register. req_tready is low while a
// bar is in the rotator; a finished result waits in the output register while
// the next bar is already accepted.
module planar_chain_forward_kinematics #(
   parameter int MAX_BARS     = 8,
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // angle [15:0], var_length [31:16]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // seg_dx [16:0], seg_dy [33:17], end_x [53:34], end_y [73:54],
   // bar_number [76:74], zero fill [79:77]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [pcfk_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0] csr_data
);

   localparam logic [3:0] MAX_N = 4'(MAX_BARS);

   // Configuration registers
   logic [3:0]   bar_count_ff;
   logic [7:0]   fixed_mask_ff;
   logic [63:0]  fixed_low_ff;
   logic [63:0]  fixed_high_ff;
   logic         angle_deg_ff;

   // Chain state
   logic [2:0]   bar_pos_ff, bar_pos_in;
   logic [3:0]   fixed_used_ff, fixed_used_in;
   logic signed [19:0] run_x_ff, run_x_in;
   logic signed [19:0] run_y_ff, run_y_in;

   // Bar in flight
   logic [2:0]   cur_pos_ff, cur_pos_in;
   logic         cur_last_ff, cur_last_in;

   // Result word register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [76:0]  rsp_data_ff, rsp_data_in;
   logic         rsp_last_ff, rsp_last_in;

   logic [3:0]   count_n;
   logic [2:0]   pos;
   logic         last;
   logic [127:0] fixed_all;
   logic [3:0]   used_base;
   logic         use_fixed;
   logic         req_accept;
   logic         start;
   logic         take;
   pcfk_pkg::rot_op_type     op;
   pcfk_pkg::rot_status_type rot_status;
   pcfk_pkg::rot_result_type rot_result;

   pcfk_rotator #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_rotator (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .op     (op),
      .take   (take),
      .status (rot_status),
      .result (rot_result)
   );

   // Decode the incoming bar against the chain state
   assign count_n    = (bar_count_ff > MAX_N) ? MAX_N : bar_count_ff;
   assign pos        = ({1'b0, bar_pos_ff} >= count_n) ? 3'd0 : bar_pos_ff;
   assign last       = (4'({1'b0, pos} + 4'd1) == count_n);
   assign fixed_all  = {fixed_high_ff, fixed_low_ff};
   // fixed lengths consumed so far, counting from zero at chain start
   assign used_base  = (pos == 3'd0) ? 4'd0 : fixed_used_ff;
   assign use_fixed  = fixed_mask_ff[pos] && !used_base[3];
   assign req_tready = rot_status.idle;
   assign req_accept = req_tvalid && req_tready;
   assign start      = req_accept && (count_n != 4'd0);
   assign take       = rot_status.res_valid && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = 1'b1;

   always_comb begin
      op.angle   = $signed(req_tdata[15:0]);
      op.degrees = angle_deg_ff;
      op.len     = req_tdata[31:16];
      bar_pos_in    = bar_pos_ff;
      fixed_used_in = fixed_used_ff;
      run_x_in      = run_x_ff;
      run_y_in      = run_y_ff;
      cur_pos_in    = cur_pos_ff;
      cur_last_in   = cur_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      // start a bar: clear at chain start, pick fixed or variable length
      if (start) begin
         if (pos == 3'd0) begin
            fixed_used_in = '0;
            run_x_in      = '0;
            run_y_in      = '0;
         end
         if (use_fixed) begin
            op.len        = fixed_all[16*used_base[2:0] +: 16];
            fixed_used_in = used_base + 4'd1;
         end
         cur_pos_in  = pos;
         cur_last_in = last;
         bar_pos_in  = last ? 3'd0 : 3'(pos + 3'd1);
      end
      // finish a bar: accumulate end point, load the result word
      if (take) begin
         run_x_in     = pcfk_pkg::sat_run(21'(run_x_ff) + 21'(rot_result.dx));
         run_y_in     = pcfk_pkg::sat_run(21'(run_y_ff) + 21'(rot_result.dy));
         rsp_valid_in = 1'b1;
         rsp_data_in  = {cur_pos_ff, run_y_in, run_x_in, rot_result.dy, rot_result.dx};
         rsp_last_in  = cur_last_ff;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bar_count_ff  <= '0;
         fixed_mask_ff <= '0;
         fixed_low_ff  <= '0;
         fixed_high_ff <= '0;
         angle_deg_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pcfk_pkg::CSR_BAR_COUNT:  bar_count_ff  <= csr_data[3:0];
            pcfk_pkg::CSR_FIXED_MASK: fixed_mask_ff <= csr_data[7:0];
            pcfk_pkg::CSR_FIXED_LOW:  fixed_low_ff  <= csr_data;
            pcfk_pkg::CSR_FIXED_HIGH: fixed_high_ff <= csr_data;
            pcfk_pkg::CSR_ANGLE_DEG:  angle_deg_ff  <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Chain state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         bar_pos_ff    <= '0;
         fixed_used_ff <= '0;
         run_x_ff      <= '0;
         run_y_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         bar_pos_ff    <= bar_pos_in;
         fixed_used_ff <= fixed_used_in;
         run_x_ff      <= run_x_in;
         run_y_ff      <= run_y_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      cur_pos_ff  <= cur_pos_in;
      cur_last_ff <= cur_last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

   // A word dropped for a zero bar count leaves the chain untouched
   a_drop_keeps_chain: assert property (@(posedge clock) disable iff (reset)
      (req_accept && count_n == 4'd0) |=> ($stable(bar_pos_ff) && $stable(run_x_ff)))
      else $error("dropped word changed chain state");

   // A started bar holds off the input until the rotator is free again
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start |=> !req_tready)
      else $error("input ready while a bar is in flight");

   // A finished rotation waits until the result register can take it
   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      (rot_status.res_valid && !take) |=> rot_status.res_valid)
      else $error("rotation result lost");

   // Loading the result register always raises rsp_tvalid
   a_take_shows: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_tvalid)
      else $error("result word not presented");

   // Bar position stays inside the chain limit
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, bar_pos_ff} < MAX_N)
      else $error("bar position out of range");

endmodule

// ===== hw/rtl/pcfk_rotator.sv =====
// Sequenced rotator: shared multiplier for phase and gain, then iterative CORDIC.
`timescale 1ns / 1ps

module pcfk_rotator #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  pcfk_pkg::rot_op_type     op,
   input  logic                     take,
   output pcfk_pkg::rot_status_type status,
   output pcfk_pkg::rot_result_type result
);

   localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);
   localparam int XY_W = pcfk_pkg::XY_W;
   localparam int Z_W  = pcfk_pkg::Z_W;

   pcfk_pkg::rot_state_type state_ff, state_in;

   logic [15:0]            len_ff, len_in;
   logic signed [15:0]     angle_ff, angle_in;
   logic                   deg_ff, deg_in;
   logic signed [XY_W-1:0] x_ff, x_in;
   logic signed [XY_W-1:0] y_ff, y_in;
   logic signed [Z_W-1:0]  z_ff, z_in;
   logic                   flip_ff, flip_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   pcfk_pkg::rot_result_type res_ff, res_in;

   // Shared multiplier: signed 17 x signed 34
   logic signed [16:0]     mul_a;
   logic signed [33:0]     mul_b;
   logic signed [50:0]     product;
   logic [31:0]            phase;
   logic signed [XY_W-1:0] xs, ys;
   logic signed [Z_W-1:0]  atan;
   logic signed [XY_W-1:0] xr, yr;
   logic signed [20:0]     xq, yq;

   assign product = 51'(mul_a) * 51'(mul_b);
   assign phase   = product[47:16];
   assign xs      = x_ff >>> step_ff;
   assign ys      = y_ff >>> step_ff;
   assign atan    = Z_W'({2'b00,
                     pcfk_pkg::ATAN_TURN[pcfk_pkg::ATAN_IDX_W'(step_ff)]});
   assign xr      = (x_ff + XY_W'(pcfk_pkg::RND_HALF)) >>> 16;
   assign yr      = (y_ff + XY_W'(pcfk_pkg::RND_HALF)) >>> 16;
   assign xq      = flip_ff ? -xr[20:0] : xr[20:0];
   assign yq      = flip_ff ? -yr[20:0] : yr[20:0];

   // Sequence one rotation
   always_comb begin
      state_in = state_ff;
      len_in   = len_ff;
      angle_in = angle_ff;
      deg_in   = deg_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      flip_in  = flip_ff;
      step_in  = step_ff;
      res_in   = res_ff;
      mul_a    = {1'b0, len_ff};
      mul_b    = {1'b0, pcfk_pkg::GAIN_Q16};
      unique case (state_ff)
         pcfk_pkg::ROT_IDLE: begin
            if (start) begin
               len_in   = op.len;
               angle_in = op.angle;
               deg_in   = op.degrees;
               state_in = pcfk_pkg::ROT_PHASE;
            end
         end
         pcfk_pkg::ROT_PHASE: begin
            // map angle to phase, fold second and third quarter by half a turn
            mul_a    = {angle_ff[15], angle_ff};
            mul_b    = {1'b0, deg_ff ? pcfk_pkg::K_DEG : pcfk_pkg::K_RAD};
            flip_in  = phase[31] ^ phase[30];
            z_in     = Z_W'($signed({phase[31] ^ (phase[31] ^ phase[30]), phase[30:0]}));
            state_in = pcfk_pkg::ROT_GAIN;
         end
         pcfk_pkg::ROT_GAIN: begin
            // prescale length by the inverse CORDIC gain
            x_in     = product[XY_W-1:0];
            y_in     = '0;
            step_in  = '0;
            state_in = pcfk_pkg::ROT_ITER;
         end
         pcfk_pkg::ROT_ITER: begin
            if (!z_ff[Z_W-1]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan;
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = pcfk_pkg::ROT_ROUND;
            end
         end
         pcfk_pkg::ROT_ROUND: begin
            res_in.dx = pcfk_pkg::sat_seg(xq);
            res_in.dy = pcfk_pkg::sat_seg(yq);
            state_in  = pcfk_pkg::ROT_HOLD;
         end
         pcfk_pkg::ROT_HOLD: begin
            if (take) begin
               state_in = pcfk_pkg::ROT_IDLE;
            end
         end
         default: begin
            state_in = pcfk_pkg::ROT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcfk_pkg::ROT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff   <= len_in;
      angle_ff <= angle_in;
      deg_ff   <= deg_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      flip_ff  <= flip_in;
      step_ff  <= step_in;
      res_ff   <= res_in;
   end

   assign status.idle      = (state_ff == pcfk_pkg::ROT_IDLE);
   assign status.res_valid = (state_ff == pcfk_pkg::ROT_HOLD);
   assign result           = res_ff;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the planar chain kinematics block: stream driver and scoreboard.
`timescale 1ns / 1ps

module tb_top;

   localparam int LIMIT_CYCLES  = 200000;
   localparam int SETTLE_CYCLES = 32;
   localparam int RANDOM_BARS   = 500;
   localparam int QUIET_AFTER   = 420;

   // Expected contents of one result word
   typedef struct {
      logic signed [16:0] seg_dx;
      logic signed [16:0] seg_dy;
      logic signed [19:0] end_x;
      logic signed [19:0] end_y;
      logic [2:0]         bar_number;
      logic               last_bar;
   } bar_result_type;

   // Chain predictor: register copy, chain state and the queue of pending results
   class chain_scoreboard;
      localparam logic [63:0] PHASE_PER_RAD = 64'd5468522205;
      localparam logic [63:0] PHASE_PER_DEG = 64'd6108397932;
      localparam longint GAIN_COMP = 39797;
      localparam int ROT_STEPS = 16;

      logic [3:0]  bar_count;
      logic [7:0]  fixed_mask;
      logic [63:0] lengths_lo;
      logic [63:0] lengths_hi;
      logic        degrees;
      logic [2:0]  position;
      logic [3:0]  fixed_used;
      longint      run_x;
      longint      run_y;
      longint      arctan_turn [16];
      bar_result_type pending_results [$];
      int          mismatches;
      int          checked;

      function new();
         arctan_turn = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                         10679838, 5340245, 2670163, 1335087, 667544, 333772,
                         166886, 83443, 41722, 20861};
         bar_count = '0;
         fixed_mask = '0;
         lengths_lo = '0;
         lengths_hi = '0;
         degrees = 1'b0;
         position = '0;
         fixed_used = '0;
         run_x = 0;
         run_y = 0;
         mismatches = 0;
         checked = 0;
      endfunction

      function longint clamp(longint v, longint lo, longint hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      function void write_reg(logic [pcfk_pkg::CSR_INDEX_W-1:0] idx, logic [63:0] value);
         case (idx)
            pcfk_pkg::CSR_BAR_COUNT: bar_count = value[3:0];
            pcfk_pkg::CSR_FIXED_MASK: fixed_mask = value[7:0];
            pcfk_pkg::CSR_FIXED_LOW: lengths_lo = value;
            pcfk_pkg::CSR_FIXED_HIGH: lengths_hi = value;
            pcfk_pkg::CSR_ANGLE_DEG: degrees = value[0];
            default: ;
         endcase
      endfunction

      // Rotate the length by the angle: phase mapping, half-turn fold, shift-add steps
      function void rotate_segment(input logic [15:0] angle, input logic [15:0] len,
                                   output longint dx, output longint dy);
         logic [63:0] angle_ext;
         logic [63:0] product;
         logic [31:0] phase;
         logic        flip;
         longint      x, y, z, xs, ys;
         int          i;
         angle_ext = {{48{angle[15]}}, angle};
         product = angle_ext * (degrees ? PHASE_PER_DEG : PHASE_PER_RAD);
         phase = product[47:16];
         flip = phase[31] ^ phase[30];
         if (flip) begin
            phase = phase + 32'h8000_0000;
         end
         z = {{32{phase[31]}}, phase};
         x = {48'd0, len};
         x = x * GAIN_COMP;
         y = 0;
         for (i = 0; i < ROT_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x = x - ys;
               y = y + xs;
               z = z - arctan_turn[i];
            end else begin
               x = x + ys;
               y = y - xs;
               z = z + arctan_turn[i];
            end
         end
         x = (x + 32768) >>> 16;
         y = (y + 32768) >>> 16;
         if (flip) begin
            x = -x;
            y = -y;
         end
         dx = clamp(x, -65535, 65535);
         dy = clamp(y, -65535, 65535);
      endfunction

      // Predict the result word of one accepted bar
      function void note_bar(logic [15:0] angle, logic [15:0] var_len);
         int          chain_len;
         logic [15:0] len;
         logic [63:0] bank;
         longint      dx, dy;
         bar_result_type r;
         chain_len = (bar_count > 8) ? 8 : int'(bar_count);
         // zero bar count: drop the word
         if (chain_len == 0) begin
            return;
         end
         // position past a lowered count restarts the chain
         if (int'(position) >= chain_len) begin
            position = '0;
         end
         if (position == 0) begin
            run_x = 0;
            run_y = 0;
            fixed_used = '0;
         end
         len = var_len;
         if (fixed_mask[position] && fixed_used < 8) begin
            bank = (fixed_used < 4) ? lengths_lo : lengths_hi;
            len = bank[16 * fixed_used[1:0] +: 16];
            fixed_used = fixed_used + 4'd1;
         end
         rotate_segment(angle, len, dx, dy);
         run_x = clamp(run_x + dx, -524288, 524287);
         run_y = clamp(run_y + dy, -524288, 524287);
         r.seg_dx = dx[16:0];
         r.seg_dy = dy[16:0];
         r.end_x = run_x[19:0];
         r.end_y = run_y[19:0];
         r.bar_number = position;
         r.last_bar = (int'(position) + 1 == chain_len);
         position = r.last_bar ? 3'd0 : position + 3'd1;
         pending_results = {pending_results, r};
      endfunction

      function void compare_field(string field, longint want, longint got);
         if (want != got) begin
            $error("%s expected %0d got %0d", field, want, got);
            mismatches++;
         end
      endfunction

      // Match one result word against the oldest prediction
      function void check_word(logic [79:0] data, logic last);
         bar_result_type r;
         if (pending_results.size() == 0) begin
            $error("result word with no bar pending");
            mismatches++;
            return;
         end
         r = pending_results.pop_front();
         checked++;
         compare_field("seg_dx", r.seg_dx, $signed(data[16:0]));
         compare_field("seg_dy", r.seg_dy, $signed(data[33:17]));
         compare_field("end_x", r.end_x, $signed(data[53:34]));
         compare_field("end_y", r.end_y, $signed(data[73:54]));
         compare_field("bar_number", r.bar_number, data[76:74]);
         compare_field("last_bar", r.last_bar, last);
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [31:0]            req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [79:0]            rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [pcfk_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [63:0]            csr_data;

   chain_scoreboard sb = new();
   bit              gaps_on;
   int              cycle_count;
   int              stall_left;
   int              random_bars;
   int              settings;

   planar_chain_forward_kinematics uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // Stall the result side in short random bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Observe every handshake at the edge it completes
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            sb.write_reg(csr_index, csr_data);
         end
         if (req_tvalid && req_tready) begin
            sb.note_bar(req_tdata[15:0], req_tdata[31:16]);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_word(rsp_tdata, rsp_tlast);
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Offer one bar word, with an optional idle burst ahead of it
   task automatic send_bar(input logic [15:0] angle, input logic [15:0] len);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {len, angle};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Write one register; the caller drops csr_valid after its last write
   task automatic csr_write(input logic [pcfk_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input logic [63:0] count_word, input logic [63:0] mask_word,
                            input logic [63:0] low_word, input logic [63:0] high_word,
                            input logic [63:0] deg_word);
      csr_write(pcfk_pkg::CSR_BAR_COUNT, count_word);
      csr_write(pcfk_pkg::CSR_FIXED_MASK, mask_word);
      csr_write(pcfk_pkg::CSR_FIXED_LOW, low_word);
      csr_write(pcfk_pkg::CSR_FIXED_HIGH, high_word);
      csr_write(pcfk_pkg::CSR_ANGLE_DEG, deg_word);
      csr_valid <= 1'b0;
      settings++;
   endtask

   // Hold the sender until every result is back and the rotator is quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [63:0] count_word, mask_word, deg_word;
      int          chain_len;
      int          n_items;
      int          idx;

      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      gaps_on = 1'b1;
      cycle_count = 0;
      stall_left = 0;
      random_bars = 0;
      settings = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero bar count after reset: words are dropped
      send_bar(16'h0000, 16'h0100);
      send_bar(16'hFFFF, 16'hFFFF);
      settle();

      // radians, three-bar chains, bar 1 on a fixed length
      configure(64'd3, 64'b010, 64'h0000_0001_8000_FFFF, 64'hFFFF_0000_1234_7FFF, 64'd0);
      send_bar(16'd0, 16'hFFFF);
      send_bar(16'd12868, 16'h1000);
      send_bar(16'd25736, 16'h0100);
      send_bar(-16'sd25736, 16'h0000);
      send_bar(16'h7FFF, 16'hFFFF);
      send_bar(16'h8000, 16'hFFFF);
      settle();

      // degrees, full chain with every bar on a fixed length
      configure(64'd8, 64'hFF, 64'h0000_0001_8000_FFFF, 64'hFFFF_0000_1234_7FFF, 64'd1);
      send_bar(16'd0, 16'h0000);
      send_bar(16'd11520, 16'h0000);
      send_bar(16'd23040, 16'h0000);
      send_bar(-16'sd11520, 16'h0000);
      send_bar(-16'sd23040, 16'h0000);
      send_bar(16'h7FFF, 16'h0000);
      send_bar(16'h8000, 16'h0000);
      send_bar(16'd5760, 16'h0000);
      settle();

      // count lowered in the middle of a chain, then unused register indexes
      configure(64'd5, 64'd0, 64'd0, 64'd0, 64'd0);
      send_bar(16'd4000, 16'h2000);
      send_bar(16'd8000, 16'h2000);
      send_bar(16'd12000, 16'h2000);
      settle();
      csr_write(pcfk_pkg::CSR_BAR_COUNT, 64'd2);
      for (idx = int'(pcfk_pkg::CSR_ANGLE_DEG) + 1; idx < (1 << pcfk_pkg::CSR_INDEX_W);
           idx++) begin
         csr_write(idx[pcfk_pkg::CSR_INDEX_W-1:0], '1);
      end
      csr_valid <= 1'b0;
      send_bar(16'd3000, 16'h0800);
      send_bar(-16'sd3000, 16'h0800);
      settle();

      // count above the chain limit, left mid chain
      configure(64'd15, 64'hA5, '1, 64'h8000_7FFF_0100_0001, 64'd1);
      send_bar(16'd1000, 16'hFFFF);
      send_bar(16'd20000, 16'h0001);
      send_bar(-16'sd20000, 16'hABCD);
      send_bar(16'd30000, 16'h5432);
      settle();

      // random settings, mostly whole chains with random bar contents
      while (random_bars < RANDOM_BARS) begin
         count_word = {$urandom, $urandom};
         case ($urandom_range(0, 9))
            0: count_word[3:0] = 4'd0;
            1: count_word[3:0] = 4'($urandom_range(9, 15));
            default: count_word[3:0] = 4'($urandom_range(1, 8));
         endcase
         mask_word = {$urandom, $urandom};
         deg_word = {$urandom, $urandom};
         configure(count_word, mask_word, {$urandom, $urandom}, {$urandom, $urandom},
                   deg_word);
         if (count_word[3:0] == 0) begin
            repeat ($urandom_range(1, 3)) send_bar(16'($urandom), 16'($urandom));
         end else begin
            chain_len = (count_word[3:0] > 8) ? 8 : int'(count_word[3:0]);
            n_items = chain_len * $urandom_range(1, 5);
            if ($urandom_range(0, 4) == 0) begin
               n_items += $urandom_range(1, chain_len);
            end
            repeat (n_items) begin
               send_bar(16'($urandom), ($urandom_range(0, 3) == 0)
                                       ? 16'($urandom_range(0, 255)) : 16'($urandom));
               random_bars++;
               if (random_bars >= QUIET_AFTER) begin
                  gaps_on = 1'b0;
               end
            end
         end
         settle();
      end

      $display("Checked %0d bar results over %0d register settings,", sb.checked, settings);
      $display("radians and degrees, fixed and variable lengths, partial and full chains.");
      if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
